>>> sv/ctap_ble_frame_reassembler_defines.svh
// Assertion macros for the CTAP BLE frame reassembler checker.
// Depends on nothing; included by the checker file.
`ifndef CTAP_BLE_FRAME_REASSEMBLER_DEFINES_SVH
`define CTAP_BLE_FRAME_REASSEMBLER_DEFINES_SVH

// Concurrent assertion on clk, inactive while rst_n is low.
`define CBFR_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same, for a property that must also hold while reset is applied.
`define CBFR_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> sv/cbfr_pkg.sv
// Shared types, codes and constants of the CTAP BLE frame reassembler.
// No dependencies; used by every RTL file of the block but cbfr_stream_if.
package cbfr_pkg;

    localparam logic [15:0] MAX_MESSAGE    = 16'd1024;
    localparam logic [7:0]  TYPE_BIT       = 8'h80;
    localparam logic [7:0]  INIT_DEFAULT   = 8'h83;
    localparam logic [7:0]  CANCEL_DEFAULT = 8'hBE;

    // register indexes
    localparam logic REG_INIT_CODE   = 1'b0;
    localparam logic REG_CANCEL_CODE = 1'b1;

    // frame kinds
    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_INIT = 2'd1;
    localparam logic [1:0] KIND_CONT = 2'd2;

    // header positions of an initial frame
    localparam logic [1:0] HDR_NONE   = 2'd0;
    localparam logic [1:0] HDR_TYPE   = 2'd1;
    localparam logic [1:0] HDR_LEN_HI = 2'd2;
    localparam logic [1:0] HDR_DONE   = 2'd3;

    // event codes
    localparam logic [2:0] EV_NONE     = 3'd0;
    localparam logic [2:0] EV_COMPLETE = 3'd1;
    localparam logic [2:0] EV_CANCEL   = 3'd2;
    localparam logic [2:0] EV_TOO_LONG = 3'd3;
    localparam logic [2:0] EV_SHORT    = 3'd4;
    localparam logic [2:0] EV_STRAY    = 3'd5;
    localparam logic [2:0] EV_UNKNOWN  = 3'd6;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       first_of_frame;
        logic       last_of_frame;
    } item_t;

    typedef struct packed {
        logic        data_valid;
        logic [7:0]  data_byte;
        logic [9:0]  byte_offset;
        logic [2:0]  event_res;
        logic [10:0] message_length;
    } result_t;

    // pipeline control shared by the stages
    typedef struct packed {
        logic item_valid;
        logic advance;
    } pipe_ctrl_t;

endpackage

>>> sv/cbfr_stream_if.sv
// Valid/ready channel interfaces for frame bytes and reassembly results.
// No dependencies.
interface cbfr_frame_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic       first_of_frame;
    logic       last_of_frame;

    modport source (output valid, output frame_byte, output first_of_frame,
                    output last_of_frame, input ready);
    modport sink   (input valid, input frame_byte, input first_of_frame,
                    input last_of_frame, output ready);
endinterface

interface cbfr_result_if;
    logic        valid;
    logic        ready;
    logic        data_valid;
    logic [7:0]  data_byte;
    logic [9:0]  byte_offset;
    logic [2:0]  event_res;
    logic [10:0] message_length;

    modport source (output valid, output data_valid, output data_byte,
                    output byte_offset, output event_res, output message_length,
                    input ready);
    modport sink   (input valid, input data_valid, input data_byte,
                    input byte_offset, input event_res, input message_length,
                    output ready);
endinterface

>>> sv/cbfr_in_stage.sv
// Input register of the reassembler: holds one frame byte request.
// Depends on cbfr_pkg.
module cbfr_in_stage (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load,
    input  cbfr_pkg::item_t    item_d,
    input  logic               advance,
    output logic               item_valid,
    output cbfr_pkg::item_t    item_q
);

    logic            valid_reg;
    logic            valid_next;
    cbfr_pkg::item_t item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= item_d;
        end
    end

    assign item_valid = valid_reg;
    assign item_q     = item_reg;

endmodule

>>> sv/cbfr_core.sv
// Reassembly state, configuration registers and per-byte decode logic.
// Depends on cbfr_pkg.
module cbfr_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic                 cfg_index,
    input  logic [7:0]           cfg_data,
    input  cbfr_pkg::pipe_ctrl_t ctrl,
    input  cbfr_pkg::item_t      item,
    output cbfr_pkg::result_t    result
);

    logic [7:0]  init_code_reg;
    logic [7:0]  cancel_code_reg;

    logic [1:0]  hdr_pos_reg,  hdr_pos_next;
    logic [1:0]  kind_reg,     kind_next;
    logic [7:0]  len_hi_reg,   len_hi_next;
    logic [10:0] exp_len_reg,  exp_len_next;
    logic [10:0] fill_reg,     fill_next;
    logic        busy_reg,     busy_next;

    logic [15:0] ann_len;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_code_reg   <= cbfr_pkg::INIT_DEFAULT;
            cancel_code_reg <= cbfr_pkg::CANCEL_DEFAULT;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                cbfr_pkg::REG_INIT_CODE:   init_code_reg   <= cfg_data;
                cbfr_pkg::REG_CANCEL_CODE: cancel_code_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign ann_len = {len_hi_reg, item.frame_byte};

    always_comb
    begin
        hdr_pos_next = hdr_pos_reg;
        kind_next    = kind_reg;
        len_hi_next  = len_hi_reg;
        exp_len_next = exp_len_reg;
        fill_next    = fill_reg;
        busy_next    = busy_reg;
        result       = '0;

        if (item.first_of_frame)
        begin
            hdr_pos_next = cbfr_pkg::HDR_NONE;
            kind_next    = cbfr_pkg::KIND_NONE;
            if (item.frame_byte == cancel_code_reg)
            begin
                fill_next        = '0;
                exp_len_next     = '0;
                busy_next        = 1'b0;
                result.event_res = cbfr_pkg::EV_CANCEL;
            end
            else if (item.frame_byte == init_code_reg)
            begin
                kind_next    = cbfr_pkg::KIND_INIT;
                hdr_pos_next = cbfr_pkg::HDR_TYPE;
            end
            else if ((item.frame_byte & cbfr_pkg::TYPE_BIT) == 8'h00)
            begin
                if (busy_reg)
                begin
                    kind_next = cbfr_pkg::KIND_CONT;
                end
                else
                begin
                    result.event_res = cbfr_pkg::EV_STRAY;
                end
            end
            else
            begin
                result.event_res = cbfr_pkg::EV_UNKNOWN;
            end
        end
        else if (kind_reg == cbfr_pkg::KIND_INIT && hdr_pos_reg == cbfr_pkg::HDR_TYPE)
        begin
            len_hi_next  = item.frame_byte;
            hdr_pos_next = cbfr_pkg::HDR_LEN_HI;
        end
        else if (kind_reg == cbfr_pkg::KIND_INIT && hdr_pos_reg == cbfr_pkg::HDR_LEN_HI)
        begin
            hdr_pos_next = cbfr_pkg::HDR_DONE;
            if (ann_len > cbfr_pkg::MAX_MESSAGE)
            begin
                fill_next        = '0;
                exp_len_next     = '0;
                busy_next        = 1'b0;
                kind_next        = cbfr_pkg::KIND_NONE;
                result.event_res = cbfr_pkg::EV_TOO_LONG;
            end
            else
            begin
                exp_len_next = ann_len[10:0];
                fill_next    = '0;
                busy_next    = 1'b1;
            end
        end
        else if ((kind_reg == cbfr_pkg::KIND_INIT && hdr_pos_reg == cbfr_pkg::HDR_DONE)
                 || kind_reg == cbfr_pkg::KIND_CONT)
        begin
            // keep the byte only while the message still has room
            if (busy_reg && fill_reg < exp_len_reg)
            begin
                result.data_valid  = 1'b1;
                result.data_byte   = item.frame_byte;
                result.byte_offset = fill_reg[9:0];
                fill_next          = fill_reg + 11'd1;
            end
        end

        if (item.last_of_frame)
        begin
            if (kind_next == cbfr_pkg::KIND_INIT && hdr_pos_next != cbfr_pkg::HDR_DONE)
            begin
                result.event_res = cbfr_pkg::EV_SHORT;
            end
            else if (kind_next != cbfr_pkg::KIND_NONE && busy_next
                     && fill_next >= exp_len_next)
            begin
                result.event_res      = cbfr_pkg::EV_COMPLETE;
                result.message_length = exp_len_next;
                fill_next             = '0;
                exp_len_next          = '0;
                busy_next             = 1'b0;
            end
            kind_next    = cbfr_pkg::KIND_NONE;
            hdr_pos_next = cbfr_pkg::HDR_NONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_pos_reg <= cbfr_pkg::HDR_NONE;
            kind_reg    <= cbfr_pkg::KIND_NONE;
            len_hi_reg  <= '0;
            exp_len_reg <= '0;
            fill_reg    <= '0;
            busy_reg    <= 1'b0;
        end
        else if (ctrl.item_valid && ctrl.advance)
        begin
            hdr_pos_reg <= hdr_pos_next;
            kind_reg    <= kind_next;
            len_hi_reg  <= len_hi_next;
            exp_len_reg <= exp_len_next;
            fill_reg    <= fill_next;
            busy_reg    <= busy_next;
        end
    end

endmodule

>>> sv/cbfr_out_stage.sv
// Result register of the reassembler: holds one result until taken.
// Depends on cbfr_pkg.
module cbfr_out_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  logic              taken,
    input  cbfr_pkg::result_t result_d,
    output logic              result_valid,
    output cbfr_pkg::result_t result_q
);

    logic              valid_reg;
    logic              valid_next;
    cbfr_pkg::result_t result_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (advance)
        begin
            valid_next = 1'b1;
        end
        else if (taken)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= result_d;
        end
    end

    assign result_valid = valid_reg;
    assign result_q     = result_reg;

endmodule

>>> sv/ctap_ble_frame_reassembler.sv
// CTAP BLE control-point frame reassembler, top level.
// Depends on cbfr_pkg, cbfr_stream_if, cbfr_in_stage, cbfr_core, cbfr_out_stage.
//
// Usage:
//   frames  - sink channel, one frame byte per request with first/last marks.
//   results - source channel, exactly one result per frame byte: a kept
//             payload byte with its message offset, and/or an event code
//             (complete, cancel, too long, short init, stray continuation,
//             unknown type). message_length is set with the complete event.
//   cfg_*   - write port for init_code (index 0) and cancel_code (index 1);
//             write only while the block is idle.
// Order: an accepted request is held in the input register; its result is
//   registered into the result register when the request advances.
// Throughput: one byte per cycle while results.ready stays high; the decode
//   of a byte and the next length and fill counts are worked out
//   combinationally between the two registers.
// Reset: both stages empty, no message in progress, codes back to 0x83/0xBE.
// Stall: while results.ready is low the result register holds; an empty input
//   register takes one more request, then frames.ready stays low until the
//   result is taken.
module ctap_ble_frame_reassembler (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic                 cfg_index,
    input  logic [7:0]           cfg_data,
    cbfr_frame_if.sink           frames,
    cbfr_result_if.source        results
);

    cbfr_pkg::item_t      item_d;
    cbfr_pkg::item_t      item_q;
    cbfr_pkg::result_t    result_d;
    cbfr_pkg::result_t    result_q;
    cbfr_pkg::pipe_ctrl_t ctrl;
    logic                 item_valid;
    logic                 result_valid;
    logic                 load;

    // Advance the held request when the result register is free or draining.
    assign ctrl.item_valid = item_valid;
    assign ctrl.advance    = item_valid && (!result_valid || results.ready);

    // Take a new request when the input register is empty or moving on.
    assign frames.ready = !item_valid || ctrl.advance;
    assign load         = frames.valid && frames.ready;

    assign item_d.frame_byte     = frames.frame_byte;
    assign item_d.first_of_frame = frames.first_of_frame;
    assign item_d.last_of_frame  = frames.last_of_frame;

    cbfr_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (load),
        .item_d     (item_d),
        .advance    (ctrl.advance),
        .item_valid (item_valid),
        .item_q     (item_q)
    );

    cbfr_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .ctrl      (ctrl),
        .item      (item_q),
        .result    (result_d)
    );

    cbfr_out_stage u_out_stage (
        .clk          (clk),
        .rst_n        (rst_n),
        .advance      (ctrl.advance),
        .taken        (results.ready),
        .result_d     (result_d),
        .result_valid (result_valid),
        .result_q     (result_q)
    );

    // Drive the result channel straight from the result register.
    assign results.valid          = result_valid;
    assign results.data_valid     = result_q.data_valid;
    assign results.data_byte      = result_q.data_byte;
    assign results.byte_offset    = result_q.byte_offset;
    assign results.event_res      = result_q.event_res;
    assign results.message_length = result_q.message_length;

endmodule

>>> sv/cbfr_checker.sv
// Port-level assertions for the CTAP BLE frame reassembler, bound to its top.
// Depends on cbfr_pkg and ctap_ble_frame_reassembler_defines.svh.
`include "ctap_ble_frame_reassembler_defines.svh"

module cbfr_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        res_valid,
    input logic        res_ready,
    input logic        data_valid,
    input logic [7:0]  data_byte,
    input logic [9:0]  byte_offset,
    input logic [2:0]  event_res,
    input logic [10:0] message_length
);

    // a kept byte never carries an error event
    `CBFR_ASSERT(a_byte_event, res_valid && data_valid |-> event_res == cbfr_pkg::EV_NONE || event_res == cbfr_pkg::EV_COMPLETE, "kept byte with error event")

    // a dropped byte shows zero payload and offset
    `CBFR_ASSERT(a_idle_payload, res_valid && !data_valid |-> data_byte == 8'h00 && byte_offset == 10'd0, "payload set on a dropped byte")

    // length only with completion, and never above the limit
    `CBFR_ASSERT(a_length, res_valid |-> (event_res == cbfr_pkg::EV_COMPLETE || message_length == 11'd0) && message_length <= cbfr_pkg::MAX_MESSAGE[10:0], "bad message length")

    // a stalled result holds
    `CBFR_ASSERT(a_hold, res_valid && !res_ready |=> res_valid && $stable(event_res) && $stable(byte_offset), "stalled result changed")

endmodule

bind ctap_ble_frame_reassembler cbfr_checker u_cbfr_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .res_valid      (results.valid),
    .res_ready      (results.ready),
    .data_valid     (results.data_valid),
    .data_byte      (results.data_byte),
    .byte_offset    (results.byte_offset),
    .event_res      (results.event_res),
    .message_length (results.message_length)
);

>>> test/ctap_ble_frame_reassembler_tb.sv
// Self-checking testbench for ctap_ble_frame_reassembler: sends frame bytes and
// checks each result against a cycle-free model of the reassembly rules.
// Depends on cbfr_pkg, cbfr_stream_if and the reassembler RTL.
module ctap_ble_frame_reassembler_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cbfr_pkg::*;

    typedef enum {PACE_NONE, PACE_SEND, PACE_RECV, PACE_BOTH} pace_t;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       cfg_we;
    logic       cfg_index;
    logic [7:0] cfg_data;

    cbfr_frame_if  frames_ch();
    cbfr_result_if results_ch();

    ctap_ble_frame_reassembler dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .frames    (frames_ch),
        .results   (results_ch)
    );

    always #5 clk = ~clk;

    // Frame bytes waiting to be offered, and the results still owed by the block.
    item_t      frame_bytes_to_send[$];
    result_t    outputs_due[$];
    logic [7:0] frame_buf[$];
    int         bytes_queued   = 0;
    int         mismatch_count = 0;
    int         send_idle_pct  = 0;
    int         recv_stall_pct = 0;

    // Shadow of the code registers, as the block should hold them.
    logic [7:0] init_code_shadow   = INIT_DEFAULT;
    logic [7:0] cancel_code_shadow = CANCEL_DEFAULT;

    // Reassembly state of the model: open frame and message being filled.
    logic [1:0]  msg_hdr_pos      = HDR_NONE;
    logic [1:0]  msg_frame_kind   = KIND_NONE;
    logic [7:0]  msg_len_hi       = '0;
    logic [10:0] msg_expected_len = '0;
    logic [10:0] msg_fill         = '0;
    logic        msg_open         = 1'b0;

    function automatic void drop_message();
        msg_fill         = '0;
        msg_expected_len = '0;
        msg_open         = 1'b0;
    endfunction

    // Advance the model by one frame byte and return the result it must produce.
    function automatic result_t reassemble_byte(item_t req);
        result_t     res;
        logic [15:0] announced;
        res       = '0;
        announced = {msg_len_hi, req.frame_byte};
        if (req.first_of_frame)
        begin
            // any first mark closes whatever frame was open, without an event
            msg_hdr_pos    = HDR_NONE;
            msg_frame_kind = KIND_NONE;
            // cancel wins over init when both codes are equal
            if (req.frame_byte == cancel_code_shadow)
            begin
                drop_message();
                res.event_res = EV_CANCEL;
            end
            else if (req.frame_byte == init_code_shadow)
            begin
                msg_frame_kind = KIND_INIT;
                msg_hdr_pos    = HDR_TYPE;
            end
            else if ((req.frame_byte & TYPE_BIT) == '0)
            begin
                if (msg_open)
                    msg_frame_kind = KIND_CONT;
                else
                    res.event_res = EV_STRAY;
            end
            else
                res.event_res = EV_UNKNOWN;
        end
        else if (msg_frame_kind == KIND_INIT && msg_hdr_pos == HDR_TYPE)
        begin
            msg_len_hi  = req.frame_byte;
            msg_hdr_pos = HDR_LEN_HI;
        end
        else if (msg_frame_kind == KIND_INIT && msg_hdr_pos == HDR_LEN_HI)
        begin
            msg_hdr_pos = HDR_DONE;
            if (announced > MAX_MESSAGE)
            begin
                drop_message();
                res.event_res  = EV_TOO_LONG;
                msg_frame_kind = KIND_NONE;
            end
            else
            begin
                msg_expected_len = announced[10:0];
                msg_fill         = '0;
                msg_open         = 1'b1;
            end
        end
        else if ((msg_frame_kind == KIND_INIT && msg_hdr_pos == HDR_DONE) ||
                 msg_frame_kind == KIND_CONT)
        begin
            // payload past the announced length is dropped silently
            if (msg_open && msg_fill < msg_expected_len)
            begin
                res.data_valid  = 1'b1;
                res.data_byte   = req.frame_byte;
                res.byte_offset = msg_fill[9:0];
                msg_fill        = msg_fill + 11'd1;
            end
        end

        if (req.last_of_frame)
        begin
            if (msg_frame_kind == KIND_INIT && msg_hdr_pos != HDR_DONE)
                res.event_res = EV_SHORT;
            else if (msg_frame_kind != KIND_NONE && msg_open &&
                     msg_fill >= msg_expected_len)
            begin
                res.event_res      = EV_COMPLETE;
                res.message_length = msg_expected_len;
                drop_message();
            end
            msg_frame_kind = KIND_NONE;
            msg_hdr_pos    = HDR_NONE;
        end
        return res;
    endfunction

    function automatic string show_result(result_t r);
        return $sformatf("valid=%0d byte=%02h offset=%0d event=%0d length=%0d",
                         r.data_valid, r.data_byte, r.byte_offset, r.event_res,
                         r.message_length);
    endfunction

    // Driver: present queued frame bytes; predict each request as it is taken.
    always @(posedge clk or negedge rst_n)
    begin : request_driver
        item_t req;
        if (!rst_n)
        begin
            frames_ch.valid          <= 1'b0;
            frames_ch.frame_byte     <= '0;
            frames_ch.first_of_frame <= 1'b0;
            frames_ch.last_of_frame  <= 1'b0;
        end
        else
        begin
            if (frames_ch.valid && frames_ch.ready)
            begin
                req.frame_byte     = frames_ch.frame_byte;
                req.first_of_frame = frames_ch.first_of_frame;
                req.last_of_frame  = frames_ch.last_of_frame;
                outputs_due.push_back(reassemble_byte(req));
            end
            // advance only when the current request is gone or none is shown
            if (!frames_ch.valid || frames_ch.ready)
            begin
                if (frame_bytes_to_send.size() != 0 &&
                    $urandom_range(99) >= send_idle_pct)
                begin
                    req = frame_bytes_to_send.pop_front();
                    frames_ch.valid          <= 1'b1;
                    frames_ch.frame_byte     <= req.frame_byte;
                    frames_ch.first_of_frame <= req.first_of_frame;
                    frames_ch.last_of_frame  <= req.last_of_frame;
                end
                else
                    frames_ch.valid <= 1'b0;
            end
        end
    end

    // Monitor: take results, match them against the oldest prediction.
    always @(posedge clk or negedge rst_n)
    begin : result_monitor
        result_t got;
        result_t want;
        if (!rst_n)
            results_ch.ready <= 1'b0;
        else
        begin
            if (results_ch.valid && results_ch.ready)
            begin
                got.data_valid     = results_ch.data_valid;
                got.data_byte      = results_ch.data_byte;
                got.byte_offset    = results_ch.byte_offset;
                got.event_res      = results_ch.event_res;
                got.message_length = results_ch.message_length;
                if (outputs_due.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t: result with nothing owed: %s", $realtime,
                                 show_result(got));
                end
                else
                begin
                    want = outputs_due.pop_front();
                    if (got.data_valid !== want.data_valid ||
                        got.data_byte !== want.data_byte ||
                        got.byte_offset !== want.byte_offset ||
                        got.event_res !== want.event_res ||
                        got.message_length !== want.message_length)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("%0t: mismatch: expected %s, got %s", $realtime,
                                     show_result(want), show_result(got));
                    end
                end
            end
            results_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    function automatic void set_pacing(pace_t p);
        send_idle_pct  = (p == PACE_SEND) ? 82 : (p == PACE_BOTH) ? 27 : 0;
        recv_stall_pct = (p == PACE_RECV) ? 82 : (p == PACE_BOTH) ? 27 : 0;
    endfunction

    function automatic void push_item(logic [7:0] b, logic first, logic last);
        item_t req;
        req.frame_byte     = b;
        req.first_of_frame = first;
        req.last_of_frame  = last;
        frame_bytes_to_send.push_back(req);
        bytes_queued++;
    endfunction

    // Queue the bytes collected in frame_buf as one frame; leave it open if !close.
    function automatic void emit_frame(bit close);
        for (int i = 0; i < frame_buf.size(); i++)
            push_item(frame_buf[i], i == 0, close && i == frame_buf.size() - 1);
        frame_buf.delete();
    endfunction

    function automatic void add_payload(int n);
        for (int i = 0; i < n; i++)
            frame_buf.push_back(8'($urandom_range(255)));
    endfunction

    function automatic logic [7:0] unknown_type();
        logic [7:0] t;
        do
            t = 8'($urandom_range(128, 255));
        while (t == init_code_shadow || t == cancel_code_shadow);
        return t;
    endfunction

    // One message: an initial frame, then continuation frames until it is full.
    // With finish low only the initial frame goes out, leaving it open.
    function automatic void send_message(logic [15:0] msg_len, int max_chunk, bit finish);
        int left;
        int chunk;
        left      = msg_len;
        frame_buf = {init_code_shadow, msg_len[15:8], msg_len[7:0]};
        do
        begin
            chunk = $urandom_range(max_chunk);
            if (chunk > left)
                chunk = left;
            add_payload(chunk);
            left -= chunk;
            // now and then run past the announced length
            if (left == 0 && $urandom_range(3) == 0)
                add_payload($urandom_range(1, 4));
            emit_frame(1'b1);
            if (left != 0 && finish)
                frame_buf.push_back(8'($urandom_range(127)));
        end
        while (left != 0 && finish);
    endfunction

    // Mostly well-formed messages with random content; the rest is noise.
    function automatic void random_traffic(int n);
        int          stop_at;
        int          pick;
        int          k;
        logic [15:0] ln;
        stop_at = bytes_queued + n;
        while (bytes_queued < stop_at)
        begin
            pick = $urandom_range(99);
            if (pick < 65)
            begin
                k = $urandom_range(99);
                if (k < 60)
                    ln = 16'($urandom_range(16));
                else if (k < 95)
                    ln = 16'($urandom_range(17, 120));
                else
                    ln = 16'($urandom_range(121, 300));
                send_message(ln, 20, $urandom_range(99) >= 15);
            end
            else if (pick < 70)
            begin
                frame_buf.push_back(cancel_code_shadow);
                add_payload($urandom_range(3));
                emit_frame(1'b1);
            end
            else if (pick < 74)
            begin
                frame_buf.push_back(unknown_type());
                add_payload($urandom_range(3));
                emit_frame(1'b1);
            end
            else if (pick < 79)
            begin
                // continuation: stray, or appending to a message left open
                frame_buf.push_back(8'($urandom_range(127)));
                add_payload($urandom_range(6));
                emit_frame(1'b1);
            end
            else if (pick < 83)
            begin
                frame_buf.push_back(init_code_shadow);
                add_payload($urandom_range(1));
                emit_frame(1'b1);
            end
            else if (pick < 87)
            begin
                ln = 16'($urandom_range(1025, 65535));
                frame_buf = {init_code_shadow, ln[15:8], ln[7:0]};
                add_payload($urandom_range(3));
                emit_frame(1'b1);
            end
            else if (pick < 91)
            begin
                // frame cut off by the next first mark
                if ($urandom_range(1))
                begin
                    frame_buf.push_back(init_code_shadow);
                    add_payload($urandom_range(1));
                end
                else
                begin
                    frame_buf.push_back(8'($urandom_range(127)));
                    add_payload($urandom_range(4));
                end
                emit_frame(1'b0);
            end
            else if (pick < 95)
            begin
                repeat ($urandom_range(1, 3))
                    push_item(8'($urandom_range(255)), 1'b0, 1'($urandom_range(1)));
            end
            else
            begin
                repeat ($urandom_range(1, 8))
                    push_item(8'($urandom_range(255)), 1'($urandom_range(1)),
                              1'($urandom_range(1)));
            end
        end
    endfunction

    // Hold off until every queued request is taken and every result is back.
    task automatic wait_drained();
        do
            @(negedge clk);
        while (frame_bytes_to_send.size() != 0 || frames_ch.valid ||
               outputs_due.size() != 0);
        repeat (3) @(negedge clk);
    endtask

    task automatic write_code(logic idx, logic [7:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        if (idx == REG_INIT_CODE)
            init_code_shadow = value;
        else
            cancel_code_shadow = value;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Drain, retune both codes while idle, then run random traffic.
    task automatic run_phase(logic [7:0] init_v, logic [7:0] cancel_v, pace_t pace,
                             int n);
        wait_drained();
        write_code(REG_INIT_CODE, init_v);
        write_code(REG_CANCEL_CODE, cancel_v);
        set_pacing(pace);
        random_traffic(n);
    endtask

    initial
    begin : stimulus
        logic [7:0] rand_init;
        logic [7:0] rand_cancel;
        rst_n                    = 1'b0;
        cfg_we                   = 1'b0;
        cfg_index                = REG_INIT_CODE;
        cfg_data                 = '0;
        frames_ch.valid          = 1'b0;
        frames_ch.frame_byte     = '0;
        frames_ch.first_of_frame = 1'b0;
        frames_ch.last_of_frame  = 1'b0;
        results_ch.ready         = 1'b0;
        set_pacing(PACE_NONE);
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Directed frames on the reset codes.
        push_item(8'h55, 1'b0, 1'b1);                            // byte outside a frame
        frame_buf = {8'h00};                     emit_frame(1'b1); // stray continuation
        frame_buf = {8'hFF};                     emit_frame(1'b1); // unknown type
        frame_buf = {CANCEL_DEFAULT, 8'h12};     emit_frame(1'b1); // cancel, tail dropped
        frame_buf = {INIT_DEFAULT, 8'h00, 8'h00}; emit_frame(1'b1); // zero length completes
        frame_buf = {INIT_DEFAULT, 8'h04, 8'h01, 8'hAA};
        emit_frame(1'b1);                                         // one over the limit
        frame_buf = {INIT_DEFAULT, 8'hFF, 8'hFF}; emit_frame(1'b1); // largest length
        frame_buf = {INIT_DEFAULT};              emit_frame(1'b1); // short init, type only
        frame_buf = {INIT_DEFAULT, 8'h00, 8'h03, 8'hAA, 8'h55};
        emit_frame(1'b1);                                         // two of three bytes
        frame_buf = {INIT_DEFAULT, 8'h00};       emit_frame(1'b1); // short init, message kept
        frame_buf = {8'h7F};                     emit_frame(1'b0); // abandoned continuation
        frame_buf = {8'h01, 8'hFF, 8'h00};       emit_frame(1'b1); // fill, excess, complete
        frame_buf = {INIT_DEFAULT, 8'h00, 8'h02, 8'h11};
        emit_frame(1'b1);
        frame_buf = {CANCEL_DEFAULT};            emit_frame(1'b1); // cancel mid-message
        frame_buf = {8'h05, 8'h22};              emit_frame(1'b1); // now stray
        frame_buf = {INIT_DEFAULT, 8'h00};       emit_frame(1'b0); // header cut short
        frame_buf = {INIT_DEFAULT, 8'h00, 8'h01, 8'h5A};
        emit_frame(1'b1);

        // Reset codes, no idling; one full-size message reaches the top offsets.
        run_phase(INIT_DEFAULT, CANCEL_DEFAULT, PACE_NONE, 30);
        send_message(MAX_MESSAGE, 240, 1'b1);

        // Code extremes, each in both registers.
        run_phase(8'h80, 8'hFF, PACE_SEND, 50);
        run_phase(8'hFF, 8'h80, PACE_RECV, 50);

        rand_init = 8'($urandom_range(128, 255));
        do
            rand_cancel = 8'($urandom_range(128, 255));
        while (rand_cancel == rand_init);
        run_phase(rand_init, rand_cancel, PACE_BOTH, 50);

        // Equal codes: every such type byte counts as a cancel.
        run_phase(8'hC7, 8'hC7, PACE_BOTH, 25);

        run_phase(INIT_DEFAULT, CANCEL_DEFAULT, PACE_SEND, 25);

        // Let the last requests and their results through, then report.
        wait_drained();
        repeat (8) @(negedge clk);
        if (mismatch_count == 0 && outputs_due.size() == 0)
            $display("ctap_ble_frame_reassembler regression: pass");
        else
            $display("ctap_ble_frame_reassembler regression: fail");
        $finish;
    end

    // Hard stop for a hung handshake.
    initial
    begin : watchdog
        #3ms;
        $display("ctap_ble_frame_reassembler regression: fail");
        $finish;
    end

endmodule
